### sv/qsf_pkg.sv
// Shared types, constants and node tables for the quadrilateral shape function evaluator.
// No dependencies; every other source file uses this package.
package qsf_pkg;

  // Default fraction bits of coordinates and results.
  localparam int FRAC_BITS_DEF = 14;

  // Internal value width and raw product width.
  localparam int VW = 32;
  localparam int PW = 2 * VW;

  // Field widths of the channels.
  localparam int CW = 16;
  localparam int RW = 17;
  localparam int NW = 4;
  localparam int KW = 2;

  // Saturation bounds of the results.
  localparam logic signed [VW-1:0] OUT_MAX = VW'(65535);
  localparam logic signed [VW-1:0] OUT_MIN = -VW'(65536);

  typedef logic signed [VW-1:0] vw_t;
  typedef logic signed [PW-1:0] pw_t;

  // Element kinds held in the configuration register.
  typedef enum logic [KW-1:0] {
    KIND_Q4   = 2'd0,
    KIND_Q8   = 2'd1,
    KIND_Q9   = 2'd2,
    KIND_RSVD = 2'd3
  } kind_e;

  // Rounding applied after the last product of the shape value.
  typedef enum logic [1:0] {
    POST_NONE    = 2'd0,
    POST_HALF    = 2'd1,
    POST_QUARTER = 2'd2
  } post_e;

  // Corner sign flags: set means the node sits at -1 along that axis.
  localparam logic CORNER_NX [4] = '{1'b1, 1'b0, 1'b0, 1'b1};
  localparam logic CORNER_NY [4] = '{1'b1, 1'b1, 1'b0, 1'b0};

  // 1D Lagrange basis per nine-node node: 0 at -1, 1 at 0, 2 at +1.
  localparam logic [1:0] LAG_X [9] = '{2'd0, 2'd2, 2'd2, 2'd0, 2'd1, 2'd2, 2'd1, 2'd0, 2'd1};
  localparam logic [1:0] LAG_Y [9] = '{2'd0, 2'd0, 2'd2, 2'd2, 2'd0, 2'd1, 2'd2, 2'd1, 2'd1};

  // Word in flight through the first half of the pipeline.
  typedef struct packed {
    logic [KW-1:0] kind;
    logic [NW-1:0] node;
    logic          last;
    vw_t           x;
    vw_t           y;
    vw_t           a;
    vw_t           b;
    vw_t           c;
    vw_t           g;
  } geo_tag_t;

  // Word in flight through the second half of the pipeline.
  typedef struct packed {
    logic [NW-1:0] node;
    logic          last;
    post_e         post;
    logic          mult_d;
    vw_t           dxd;
    vw_t           dyd;
  } out_tag_t;

  // Index of the final node for a kind; has_nodes clear for the unused code.
  function automatic logic [NW-1:0] last_index(input logic [KW-1:0] kind);
    case (kind)
      KIND_Q4: last_index = NW'(3);
      KIND_Q8: last_index = NW'(7);
      KIND_Q9: last_index = NW'(8);
      default: last_index = '0;
    endcase
  endfunction

  function automatic logic has_nodes(input logic [KW-1:0] kind);
    case (kind)
      KIND_Q4, KIND_Q8, KIND_Q9: has_nodes = 1'b1;
      default: has_nodes = 1'b0;
    endcase
  endfunction

  // Clamp an internal value to the signed 17-bit result range.
  function automatic logic signed [RW-1:0] sat(input vw_t v);
    vw_t s;
    s = v;
    if (v > OUT_MAX) s = OUT_MAX;
    if (v < OUT_MIN) s = OUT_MIN;
    sat = s[RW-1:0];
  endfunction

endpackage

### sv/qsf_if.sv
// Channel interfaces: coordinate input, node result output, configuration write.
// Depends on qsf_pkg for field widths.
interface qsf_coord_if;
  logic                             valid;
  logic                             ready;
  logic signed [qsf_pkg::CW-1:0]    xi_coord;
  logic signed [qsf_pkg::CW-1:0]    eta_coord;
  modport source (output valid, xi_coord, eta_coord, input ready);
  modport sink   (input valid, xi_coord, eta_coord, output ready);
endinterface

interface qsf_node_if;
  logic                             valid;
  logic                             ready;
  logic [qsf_pkg::NW-1:0]           node_index;
  logic signed [qsf_pkg::RW-1:0]    shape_value;
  logic signed [qsf_pkg::RW-1:0]    deriv_xi;
  logic signed [qsf_pkg::RW-1:0]    deriv_eta;
  logic                             last_node;
  modport source (output valid, node_index, shape_value, deriv_xi, deriv_eta, last_node,
                  input ready);
  modport sink   (input valid, node_index, shape_value, deriv_xi, deriv_eta, last_node,
                  output ready);
endinterface

interface qsf_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [qsf_pkg::KW-1:0]           element_kind;
  modport source (output valid, element_kind, input ready);
  modport sink   (input valid, element_kind, output ready);
endinterface

### sv/quad_shape_function_eval.sv
// Q4/Q8/Q9 shape functions: a node sequencer feeds a five-stage product pipeline.
// Throughput: one node word per cycle while the result channel takes words; a coordinate
// yields 4, 8 or 9 node words (node count of the element kind); kind 3 yields none.
// Reset: asynchronous active low; clears the kind register (four-node) and all valids.
// Depends on qsf_pkg and the channel interfaces in qsf_if.sv.
module quad_shape_function_eval #(
  parameter int FRAC_BITS = qsf_pkg::FRAC_BITS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  qsf_coord_if.sink   coord_i,
  qsf_node_if.source  node_o,
  qsf_cfg_if.sink     cfg_i
);
  import qsf_pkg::*;

  localparam vw_t ONE = vw_t'(1) <<< FRAC_BITS;

  // Round a raw product back to the value scale, to nearest, ties up.
  function automatic vw_t rnd(input pw_t p);
    pw_t s;
    s = (p + (pw_t'(1) <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
    rnd = s[VW-1:0];
  endfunction

  function automatic vw_t half_r(input vw_t v);
    half_r = (v + vw_t'(1)) >>> 1;
  endfunction

  function automatic vw_t quarter_r(input vw_t v);
    quarter_r = (v + vw_t'(2)) >>> 2;
  endfunction

  function automatic pw_t mul(input vw_t a, input vw_t b);
    mul = pw_t'(a) * pw_t'(b);
  endfunction

  // 1D quadratic Lagrange value from the rounded product, and derivative.
  function automatic vw_t lag_val(input logic [1:0] sel, input vw_t r);
    if (sel == 2'd1) lag_val = ONE - r;
    else             lag_val = half_r(r);
  endfunction

  function automatic vw_t lag_der(input logic [1:0] sel, input vw_t t);
    case (sel)
      2'd0:    lag_der = half_r((t <<< 1) - ONE);
      2'd1:    lag_der = -(t <<< 1);
      default: lag_der = half_r((t <<< 1) + ONE);
    endcase
  endfunction

  logic en;

  // ---------------------------------------------------------------- config
  logic [KW-1:0] kind_q;
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kind_q <= KIND_Q4;
    end else if (cfg_i.valid) begin
      kind_q <= cfg_i.element_kind;
    end
  end

  // ---------------------------------------------------------------- node sequencer
  logic                 busy_q;
  logic [NW-1:0]        node_q;
  logic [KW-1:0]        it_kind_q;
  logic signed [CW-1:0] x_q, y_q;
  logic                 it_last;
  logic                 take;

  assign it_last       = (node_q == last_index(it_kind_q));
  assign coord_i.ready = en && (!busy_q || it_last);
  assign take          = coord_i.valid && coord_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      node_q <= '0;
    end else if (take) begin
      busy_q <= has_nodes(kind_q);
      node_q <= '0;
    end else if (en && busy_q) begin
      // advance to the next node, drop busy after the last one
      if (it_last) busy_q <= 1'b0;
      else         node_q <= node_q + NW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      x_q       <= coord_i.xi_coord;
      y_q       <= coord_i.eta_coord;
      it_kind_q <= kind_q;
    end
  end

  // ---------------------------------------------------------------- stage A: first operands
  vw_t      ax, ay;
  logic     nx, ny, ty, su_neg;
  vw_t      t_s, u_s;
  vw_t      m0a, m0b, m1a, m1b, m2a, m2b;
  geo_tag_t tag_a;

  always_comb begin
    ax     = {{(VW-CW){x_q[CW-1]}}, x_q};
    ay     = {{(VW-CW){y_q[CW-1]}}, y_q};
    nx     = CORNER_NX[node_q[1:0]];
    ny     = CORNER_NY[node_q[1:0]];
    ty     = node_q[0];
    su_neg = ~(node_q[0] ^ node_q[1]);
    t_s    = ty ? ay : ax;
    u_s    = ty ? ax : ay;

    tag_a.kind = it_kind_q;
    tag_a.node = node_q;
    tag_a.last = it_last;
    tag_a.x    = ax;
    tag_a.y    = ay;
    tag_a.a    = nx ? ONE - ax : ONE + ax;
    tag_a.b    = ny ? ONE - ay : ONE + ay;
    tag_a.c    = -ONE + (nx ? -ax : ax) + (ny ? -ay : ay);
    tag_a.g    = su_neg ? ONE - u_s : ONE + u_s;

    m0a = '0; m0b = '0; m1a = '0; m1b = '0; m2a = '0; m2b = '0;
    case (it_kind_q)
      KIND_Q8: begin
        if (node_q < NW'(4)) begin
          m0a = tag_a.a; m0b = tag_a.b;
          m1a = tag_a.b; m1b = (ax <<< 1) + ((nx ^ ny) ? -ay : ay);
          m2a = tag_a.a; m2b = (ay <<< 1) + ((nx ^ ny) ? -ax : ax);
        end else begin
          m0a = t_s; m0b = t_s;
          m1a = t_s; m1b = tag_a.g;
        end
      end
      KIND_Q9: begin
        m0a = ax;
        case (LAG_X[node_q])
          2'd0:    m0b = ax - ONE;
          2'd1:    m0b = ax;
          default: m0b = ax + ONE;
        endcase
        m1a = ay;
        case (LAG_Y[node_q])
          2'd0:    m1b = ay - ONE;
          2'd1:    m1b = ay;
          default: m1b = ay + ONE;
        endcase
      end
      default: ;
    endcase
  end

  logic     va_q;
  vw_t      m0a_q, m0b_q, m1a_q, m1b_q, m2a_q, m2b_q;
  geo_tag_t tag_a_q;

  // ---------------------------------------------------------------- stage B: first products
  logic     vb_q;
  pw_t      p0_q, p1_q, p2_q;
  geo_tag_t tag_b_q;

  // ---------------------------------------------------------------- stage C: second operands
  vw_t      r0, r1, r2, t2, lx, ly, dlx, dly, hv, along;
  logic [1:0] sx_sel, sy_sel;
  vw_t      n0a, n0b, n1a, n1b, n2a, n2b;
  out_tag_t tag_c;

  always_comb begin
    r0     = rnd(p0_q);
    r1     = rnd(p1_q);
    r2     = rnd(p2_q);
    t2     = ONE - r0;
    hv     = half_r(t2);
    along  = -r1;
    sx_sel = LAG_X[tag_b_q.node];
    sy_sel = LAG_Y[tag_b_q.node];
    lx     = lag_val(sx_sel, r0);
    ly     = lag_val(sy_sel, r1);
    dlx    = lag_der(sx_sel, tag_b_q.x);
    dly    = lag_der(sy_sel, tag_b_q.y);

    tag_c.node   = tag_b_q.node;
    tag_c.last   = tag_b_q.last;
    tag_c.post   = POST_QUARTER;
    tag_c.mult_d = 1'b0;
    tag_c.dxd    = '0;
    tag_c.dyd    = '0;
    n0a = '0; n0b = '0; n1a = '0; n1b = '0; n2a = '0; n2b = '0;
    case (tag_b_q.kind)
      KIND_Q4: begin
        n0a = tag_b_q.a; n0b = tag_b_q.b;
        tag_c.dxd = quarter_r(CORNER_NX[tag_b_q.node[1:0]] ? -tag_b_q.b : tag_b_q.b);
        tag_c.dyd = quarter_r(CORNER_NY[tag_b_q.node[1:0]] ? -tag_b_q.a : tag_b_q.a);
      end
      KIND_Q8: begin
        if (tag_b_q.node < NW'(4)) begin
          n0a = r0; n0b = tag_b_q.c;
          tag_c.dxd = quarter_r(r1);
          tag_c.dyd = quarter_r(r2);
        end else begin
          n0a = t2; n0b = tag_b_q.g;
          tag_c.post = POST_HALF;
          // the across-axis term takes the sign of the fixed coordinate
          if (tag_b_q.node[0]) begin
            tag_c.dxd = ~(tag_b_q.node[0] ^ tag_b_q.node[1]) ? -hv : hv;
            tag_c.dyd = along;
          end else begin
            tag_c.dxd = along;
            tag_c.dyd = ~(tag_b_q.node[0] ^ tag_b_q.node[1]) ? -hv : hv;
          end
        end
      end
      KIND_Q9: begin
        n0a = lx;  n0b = ly;
        n1a = dlx; n1b = ly;
        n2a = lx;  n2b = dly;
        tag_c.post   = POST_NONE;
        tag_c.mult_d = 1'b1;
      end
      default: ;
    endcase
  end

  logic     vc_q;
  vw_t      n0a_q, n0b_q, n1a_q, n1b_q, n2a_q, n2b_q;
  out_tag_t tag_c_q;

  // ---------------------------------------------------------------- stage D: second products
  logic     vd_q;
  pw_t      q0_q, q1_q, q2_q;
  out_tag_t tag_d_q;

  // ---------------------------------------------------------------- stage E: round, saturate
  vw_t sv, svr, dxv, dyv;

  always_comb begin
    svr = rnd(q0_q);
    case (tag_d_q.post)
      POST_HALF:    sv = half_r(svr);
      POST_QUARTER: sv = quarter_r(svr);
      default:      sv = svr;
    endcase
    dxv = tag_d_q.mult_d ? rnd(q1_q) : tag_d_q.dxd;
    dyv = tag_d_q.mult_d ? rnd(q2_q) : tag_d_q.dyd;
  end

  logic                 out_valid_q;
  logic [NW-1:0]        out_node_q;
  logic signed [RW-1:0] out_n_q, out_dx_q, out_dy_q;
  logic                 out_last_q;

  // advance every stage together whenever the output register frees up
  assign en = !out_valid_q || node_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q        <= 1'b0;
      vb_q        <= 1'b0;
      vc_q        <= 1'b0;
      vd_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (en) begin
      va_q        <= busy_q;
      vb_q        <= va_q;
      vc_q        <= vb_q;
      vd_q        <= vc_q;
      out_valid_q <= vd_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      m0a_q <= m0a; m0b_q <= m0b;
      m1a_q <= m1a; m1b_q <= m1b;
      m2a_q <= m2a; m2b_q <= m2b;
      tag_a_q <= tag_a;

      p0_q <= mul(m0a_q, m0b_q);
      p1_q <= mul(m1a_q, m1b_q);
      p2_q <= mul(m2a_q, m2b_q);
      tag_b_q <= tag_a_q;

      n0a_q <= n0a; n0b_q <= n0b;
      n1a_q <= n1a; n1b_q <= n1b;
      n2a_q <= n2a; n2b_q <= n2b;
      tag_c_q <= tag_c;

      q0_q <= mul(n0a_q, n0b_q);
      q1_q <= mul(n1a_q, n1b_q);
      q2_q <= mul(n2a_q, n2b_q);
      tag_d_q <= tag_c_q;

      out_node_q <= tag_d_q.node;
      out_last_q <= tag_d_q.last;
      out_n_q    <= sat(sv);
      out_dx_q   <= sat(dxv);
      out_dy_q   <= sat(dyv);
    end
  end

  assign node_o.valid       = out_valid_q;
  assign node_o.node_index  = out_node_q;
  assign node_o.shape_value = out_n_q;
  assign node_o.deriv_xi    = out_dx_q;
  assign node_o.deriv_eta   = out_dy_q;
  assign node_o.last_node   = out_last_q;

endmodule

### sv/qsf_checker.sv
// Port-level checks on the result channel of the shape function evaluator.
// Depends on qsf_pkg; bound to quad_shape_function_eval below.
module qsf_port_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          out_valid_i,
  input logic                          out_ready_i,
  input logic [qsf_pkg::NW-1:0]        node_index_i,
  input logic signed [qsf_pkg::RW-1:0] shape_value_i,
  input logic                          last_node_i
);
  import qsf_pkg::*;

  // hold a stalled result word
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(node_index_i)
      && $stable(shape_value_i) && $stable(last_node_i))
    else $error("stalled result word changed");

  a_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> node_index_i <= NW'(8))
    else $error("node index out of range");

  a_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && last_node_i |-> node_index_i == NW'(3) || node_index_i == NW'(7)
      || node_index_i == NW'(8))
    else $error("last flag on a node that is no final node");

  a_nine: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && node_index_i == NW'(8) |-> last_node_i)
    else $error("node eight without last flag");

endmodule

bind quad_shape_function_eval qsf_port_checker u_qsf_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .out_valid_i   (node_o.valid),
  .out_ready_i   (node_o.ready),
  .node_index_i  (node_o.node_index),
  .shape_value_i (node_o.shape_value),
  .last_node_i   (node_o.last_node)
);

### sim/qsf_checker.sv
// Watches the coordinate, node result and configuration channels of the shape function evaluator.
// Predicts node words from each accepted coordinate and compares them; depends on qsf_pkg, qsf_if.
module qsf_checker (
  input  logic              clk_i,
  input  logic              rst_ni,
  qsf_coord_if.sink         coord_m,
  qsf_node_if.sink          node_m,
  qsf_cfg_if.sink           cfg_m,
  output int                fail_count_o,
  output int                pending_o
);
  timeunit 1ns;
  timeprecision 1ps;
  import qsf_pkg::*;

  localparam int FB = FRAC_BITS_DEF;
  localparam longint ONE = longint'(1) << FB;

  typedef struct {
    logic [NW-1:0]        node;
    logic signed [RW-1:0] shape;
    logic signed [RW-1:0] dxi;
    logic signed [RW-1:0] deta;
    logic                 last;
  } node_word_t;

  node_word_t expected_nodes[$];
  logic [KW-1:0] kind_reg;

  assign pending_o = expected_nodes.size();

  // Round to nearest, ties toward plus infinity (arithmetic shift floors).
  function automatic longint rnd_shift(longint v, int s);
    return (v + (longint'(1) << (s - 1))) >>> s;
  endfunction

  function automatic longint fx_mul(longint a, longint b);
    return rnd_shift(a * b, FB);
  endfunction

  function automatic logic signed [RW-1:0] clamp17(longint v);
    if (v > 65535) v = 65535;
    if (v < -65536) v = -65536;
    return v[RW-1:0];
  endfunction

  function automatic void push_node(int k, int last, longint n, longint dx, longint dy);
    node_word_t w;
    w.node = k[NW-1:0];
    w.shape = clamp17(n);
    w.dxi = clamp17(dx);
    w.deta = clamp17(dy);
    w.last = (k == last);
    expected_nodes.push_back(w);
  endfunction

  // 1D quadratic Lagrange basis for nodes at -1, 0, +1.
  function automatic void lag_basis(longint t, output longint l[3], output longint d[3]);
    l[0] = rnd_shift(fx_mul(t, t - ONE), 1);
    l[1] = ONE - fx_mul(t, t);
    l[2] = rnd_shift(fx_mul(t, t + ONE), 1);
    d[0] = rnd_shift(2 * t - ONE, 1);
    d[1] = -2 * t;
    d[2] = rnd_shift(2 * t + ONE, 1);
  endfunction

  function automatic void predict_nodes(logic signed [CW-1:0] xi, logic signed [CW-1:0] eta);
    longint x, y, sx, sy, fx, fy, xm, xp, ym, yp, x2, y2;
    longint n[8], dx[8], dy[8], lx[3], dlx[3], ly[3], dly[3];
    x = xi;
    y = eta;
    case (kind_reg)
      KIND_Q4: begin
        for (int k = 0; k < 4; k++) begin
          sx = CORNER_NX[k] ? -1 : 1;
          sy = CORNER_NY[k] ? -1 : 1;
          fx = ONE + sx * x;
          fy = ONE + sy * y;
          push_node(k, 3, rnd_shift(fx_mul(fx, fy), 2), rnd_shift(sx * fy, 2),
                    rnd_shift(sy * fx, 2));
        end
      end
      KIND_Q8: begin
        xm = ONE - x; xp = ONE + x; ym = ONE - y; yp = ONE + y;
        x2 = ONE - fx_mul(x, x);
        y2 = ONE - fx_mul(y, y);
        n[0] = rnd_shift(fx_mul(fx_mul(xm, ym), -ONE - x - y), 2);
        n[1] = rnd_shift(fx_mul(fx_mul(xp, ym), -ONE + x - y), 2);
        n[2] = rnd_shift(fx_mul(fx_mul(xp, yp), -ONE + x + y), 2);
        n[3] = rnd_shift(fx_mul(fx_mul(xm, yp), -ONE - x + y), 2);
        n[4] = rnd_shift(fx_mul(x2, ym), 1);
        n[5] = rnd_shift(fx_mul(y2, xp), 1);
        n[6] = rnd_shift(fx_mul(x2, yp), 1);
        n[7] = rnd_shift(fx_mul(y2, xm), 1);
        dx[0] = rnd_shift(fx_mul(ym, 2 * x + y), 2);
        dx[1] = rnd_shift(fx_mul(ym, 2 * x - y), 2);
        dx[2] = rnd_shift(fx_mul(yp, 2 * x + y), 2);
        dx[3] = rnd_shift(fx_mul(yp, 2 * x - y), 2);
        dx[4] = -fx_mul(x, ym);
        dx[5] = rnd_shift(y2, 1);
        dx[6] = -fx_mul(x, yp);
        dx[7] = -rnd_shift(y2, 1);
        dy[0] = rnd_shift(fx_mul(xm, 2 * y + x), 2);
        dy[1] = rnd_shift(fx_mul(xp, 2 * y - x), 2);
        dy[2] = rnd_shift(fx_mul(xp, 2 * y + x), 2);
        dy[3] = rnd_shift(fx_mul(xm, 2 * y - x), 2);
        dy[4] = -rnd_shift(x2, 1);
        dy[5] = -fx_mul(y, xp);
        dy[6] = rnd_shift(x2, 1);
        dy[7] = -fx_mul(y, xm);
        for (int k = 0; k < 8; k++) push_node(k, 7, n[k], dx[k], dy[k]);
      end
      KIND_Q9: begin
        lag_basis(x, lx, dlx);
        lag_basis(y, ly, dly);
        for (int k = 0; k < 9; k++) begin
          push_node(k, 8, fx_mul(lx[LAG_X[k]], ly[LAG_Y[k]]),
                    fx_mul(dlx[LAG_X[k]], ly[LAG_Y[k]]), fx_mul(lx[LAG_X[k]], dly[LAG_Y[k]]));
        end
      end
      default: ;  // unused kind: no node words
    endcase
  endfunction

  // Track the register, predict on each coordinate word, compare each node word.
  always @(posedge clk_i or negedge rst_ni) begin
    node_word_t w;
    if (!rst_ni) begin
      kind_reg <= KIND_Q4;
      fail_count_o <= 0;
      expected_nodes.delete();
    end else begin
      if (cfg_m.valid && cfg_m.ready) kind_reg <= cfg_m.element_kind;
      if (coord_m.valid && coord_m.ready) predict_nodes(coord_m.xi_coord, coord_m.eta_coord);
      if (node_m.valid && node_m.ready) begin
        if (expected_nodes.size() == 0) begin
          $error("node word with nothing expected: node %0d", node_m.node_index);
          fail_count_o <= fail_count_o + 1;
        end else begin
          w = expected_nodes.pop_front();
          if (node_m.node_index !== w.node || node_m.shape_value !== w.shape ||
              node_m.deriv_xi !== w.dxi || node_m.deriv_eta !== w.deta ||
              node_m.last_node !== w.last) begin
            if (node_m.node_index !== w.node)
              $error("node_index: expected %0d, got %0d", w.node, node_m.node_index);
            if (node_m.shape_value !== w.shape)
              $error("shape_value: expected %0d, got %0d", w.shape, node_m.shape_value);
            if (node_m.deriv_xi !== w.dxi)
              $error("deriv_xi: expected %0d, got %0d", w.dxi, node_m.deriv_xi);
            if (node_m.deriv_eta !== w.deta)
              $error("deriv_eta: expected %0d, got %0d", w.deta, node_m.deriv_eta);
            if (node_m.last_node !== w.last)
              $error("last_node: expected %0d, got %0d", w.last, node_m.last_node);
            fail_count_o <= fail_count_o + 1;
          end
        end
      end
    end
  end
endmodule

### sim/quad_shape_function_eval_tb.sv
// Top of the shape function evaluator testbench: clock, reset, coordinate and register stimulus.
// Depends on qsf_pkg, qsf_if, the block and qsf_checker.
module quad_shape_function_eval_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import qsf_pkg::*;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  int   fail_count, pending;
  int   send_idle = 0, recv_stall = 0;
  bit   hold_off = 1'b0;

  qsf_coord_if coord_ch();
  qsf_node_if  node_ch();
  qsf_cfg_if   cfg_ch();

  quad_shape_function_eval DUT (
    .clk_i (clk_i), .rst_ni(rst_ni), .coord_i(coord_ch), .node_o(node_ch), .cfg_i(cfg_ch)
  );

  qsf_checker u_checker (
    .clk_i(clk_i), .rst_ni(rst_ni), .coord_m(coord_ch), .node_m(node_ch), .cfg_m(cfg_ch),
    .fail_count_o(fail_count), .pending_o(pending)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Receiver: stall at the phase's rate, or hold off entirely during the pressure test.
  always @(posedge clk_i) begin
    node_ch.ready <= !hold_off && ($urandom_range(99) >= recv_stall);
  end

  // Offer one coordinate word and hold it until accepted.
  task automatic send_coord(logic signed [CW-1:0] xi, logic signed [CW-1:0] eta);
    while ($urandom_range(99) < send_idle) begin
      coord_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    coord_ch.valid <= 1'b1;
    coord_ch.xi_coord <= xi;
    coord_ch.eta_coord <= eta;
    do @(posedge clk_i); while (!coord_ch.ready);
  endtask

  // Drain all expected words, let the pipeline empty, then write the kind.
  task automatic set_kind(logic [KW-1:0] kind);
    coord_ch.valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (12) @(posedge clk_i);
    cfg_ch.valid <= 1'b1;
    cfg_ch.element_kind <= kind;
    do @(posedge clk_i); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
  endtask

  // Mostly in-range coordinates, some anywhere in 16 bits.
  function automatic logic signed [CW-1:0] rand_coord();
    case ($urandom_range(9))
      0: return CW'($urandom);
      1: return ($urandom_range(1)) ? 16'sd16384 : -16'sd16384;
      default: return CW'($signed($urandom_range(32768)) - 16384);
    endcase
  endfunction

  task automatic directed_set();
    send_coord(-16'sd16384, -16'sd16384);
    send_coord(16'sd16384, 16'sd16384);
    send_coord(16'sd0, 16'sd0);
    send_coord(16'sh7fff, 16'sh8000);
    send_coord(16'sh8000, 16'sh7fff);
    send_coord(16'sd1, -16'sd1);
  endtask

  initial begin
    logic [KW-1:0] kinds[5];
    coord_ch.valid = 1'b0;
    coord_ch.xi_coord = '0;
    coord_ch.eta_coord = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.element_kind = KIND_Q4;
    kinds = '{KIND_Q8, KIND_Q9, KIND_RSVD, KIND_Q4, KIND_Q9};
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: extreme and special coordinates under every kind, reset kind first.
    directed_set();
    foreach (kinds[i]) begin
      set_kind(kinds[i]);
      if (i < 3) directed_set();
    end

    // Random phases: no idling, sender idle, receiver stall, both; kinds rotate.
    for (int ph = 0; ph < 8; ph++) begin
      set_kind(ph % 4 == 3 ? KIND_RSVD : KW'(ph % 3));
      case (ph % 4)
        0: begin send_idle = 0;  recv_stall = 0;  end
        1: begin send_idle = 77; recv_stall = 0;  end
        2: begin send_idle = 0;  recv_stall = 77; end
        default: begin send_idle = 8; recv_stall = 8; end
      endcase
      repeat (ph % 4 == 3 ? 20 : 55) send_coord(rand_coord(), rand_coord());
    end

    // Pressure: receiver holds off while the sender keeps offering words.
    set_kind(KIND_Q9);
    send_idle = 0;
    recv_stall = 0;
    hold_off = 1'b1;
    fork
      repeat (20) send_coord(rand_coord(), rand_coord());
      begin
        repeat (300) @(posedge clk_i);
        hold_off = 1'b0;
      end
    join
    // Sender pauses until every word has come, then sends a final burst.
    coord_ch.valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (10) send_coord(rand_coord(), rand_coord());

    coord_ch.valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("quad_shape_function_eval test passed");
    end else begin
      $display("quad_shape_function_eval test failed");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("quad_shape_function_eval test failed");
    $finish;
  end
endmodule

### sim.f
sv/qsf_pkg.sv
sv/qsf_if.sv
sv/quad_shape_function_eval.sv
sv/qsf_checker.sv
sim/qsf_checker.sv
sim/quad_shape_function_eval_tb.sv
